// ===== rtl/afr_pkg.sv =====
// Shared types and constants of the adapter frame receiver.
package afr_pkg;

  localparam logic [7:0] StartByte    = 8'hAA;
  localparam logic [7:0] StopByte     = 8'h55;
  localparam logic [7:0] SettingsInfo = 8'h55;
  localparam logic [3:0] DataNibble   = 4'hC;
  localparam logic [4:0] DataBaseLen  = 5'd5;
  localparam logic [4:0] SettingsLen  = 5'd20;
  localparam logic [4:0] ShortLen     = 5'd2;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    KIND_SHORT    = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_SETTINGS = 2'd2
  } afr_kind_e;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_NO_STOP  = 2'd2
  } afr_status_e;

  // One received byte with the tests that need no frame state.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_start;
    logic       is_settings;
    logic       is_data;
    logic [4:0] data_len;
  } afr_item_t;

endpackage

// ===== rtl/afr_front.sv =====
// Front end: accept request bytes and classify them for the frame tracker.
module afr_front
  import afr_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output afr_item_t  q_item_o
);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.rx_byte     = rx_byte_i;
    q_item_o.is_start    = (rx_byte_i == StartByte);
    q_item_o.is_settings = (rx_byte_i == SettingsInfo);
    q_item_o.is_data     = (rx_byte_i[7:4] == DataNibble);
    q_item_o.data_len    = DataBaseLen + {1'b0, rx_byte_i[3:0]};
  end

endmodule

// ===== rtl/afr_queue.sv =====
// Small register queue between the front end and the frame tracker.
module afr_queue
  import afr_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  afr_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output afr_item_t item_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  afr_item_t       slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/afr_tracker.sv =====
// Back end: track frame position, length and checksum; register each result.
module afr_tracker
  import afr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  afr_item_t  q_item_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic [4:0] position_o,
  output logic       frame_end_o,
  output logic [1:0] frame_kind_o,
  output logic [1:0] status_o
);

  logic [4:0]  count_q, count_d;
  logic        start_ok_q, start_ok_d;
  afr_kind_e   kind_q, kind_d;
  logic [7:0]  sum_q, sum_d;
  logic [4:0]  exp_len_q, exp_len_d;

  logic        valid_q;
  logic [7:0]  byte_q;
  logic [4:0]  pos_q;
  logic        end_q;
  afr_kind_e   okind_q;
  afr_status_e ostat_q;

  afr_kind_e   kind_now;
  afr_status_e stat_now;
  logic        end_now;
  logic [4:0]  len_now;

  // Take the next byte when the result register is empty or being drained.
  assign q_pop_o = !q_empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    count_d    = count_q;
    start_ok_d = start_ok_q;
    kind_d     = kind_q;
    sum_d      = sum_q;
    exp_len_d  = exp_len_q;
    kind_now   = KIND_SHORT;
    stat_now   = ST_GOOD;
    end_now    = 1'b0;
    len_now    = exp_len_q;

    if (count_q == 5'd0) begin
      start_ok_d = q_item_i.is_start;
      sum_d      = '0;
      exp_len_d  = ShortLen;
    end else begin
      if (count_q == 5'd1) begin
        if (start_ok_q && q_item_i.is_settings) begin
          kind_now = KIND_SETTINGS;
          len_now  = SettingsLen;
        end else if (start_ok_q && q_item_i.is_data) begin
          kind_now = KIND_DATA;
          len_now  = q_item_i.data_len;
        end else begin
          kind_now = KIND_SHORT;
          len_now  = ShortLen;
        end
        kind_d    = kind_now;
        exp_len_d = len_now;
      end else begin
        kind_now = kind_q;
      end

      if ({1'b0, count_q} + 6'd1 >= {1'b0, len_now}) begin
        end_now = 1'b1;
        if (kind_now == KIND_SETTINGS) begin
          if (q_item_i.rx_byte != sum_q) stat_now = ST_CHECKSUM;
        end else if (q_item_i.rx_byte != StopByte) begin
          stat_now = ST_NO_STOP;
        end
      end else if (count_q >= 5'd2) begin
        sum_d = sum_q + q_item_i.rx_byte;
      end
    end

    if (end_now) begin
      count_d   = '0;
      exp_len_d = ShortLen;
      sum_d     = '0;
    end else begin
      count_d = count_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      start_ok_q <= 1'b0;
      kind_q     <= KIND_SHORT;
      sum_q      <= '0;
      exp_len_q  <= ShortLen;
      valid_q    <= 1'b0;
    end else begin
      if (q_pop_o) begin
        count_q    <= count_d;
        start_ok_q <= start_ok_d;
        kind_q     <= kind_d;
        sum_q      <= sum_d;
        exp_len_q  <= exp_len_d;
        valid_q    <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      byte_q  <= q_item_i.rx_byte;
      pos_q   <= count_q;
      end_q   <= end_now;
      okind_q <= kind_now;
      ostat_q <= stat_now;
    end
  end

  assign out_valid_o  = valid_q;
  assign byte_out_o   = byte_q;
  assign position_o   = pos_q;
  assign frame_end_o  = end_q;
  assign frame_kind_o = okind_q;
  assign status_o     = ostat_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (pos_q <= 5'd19))
    else $error("position beyond settings frame length");

  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !end_q) |-> (ostat_q == ST_GOOD))
    else $error("status raised before frame end");

  a_first_byte_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && pos_q == 5'd0) |-> (okind_q == KIND_SHORT && !end_q))
    else $error("first byte of frame carries a kind or an end");

  a_end_resets_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && end_now) |=> (count_q == 5'd0 && exp_len_q == ShortLen))
    else $error("frame end did not restart the frame");

endmodule

// ===== rtl/adapter_frame_receiver.sv =====
// Top level of the adapter frame receiver: front end, queue and frame tracker.
// Data path: an accepted request byte is stored in the queue, then its result in the result register.
// Throughput: one byte per cycle while neither side stalls; the front end stores into a two-entry queue and the
//   tracker drains it into a result register, so input and output stall independently.
// Reset (rst_ni low, asynchronous): queue emptied, no result pending, frame state
//   back to the start of a frame with an expected length of two bytes.
module adapter_frame_receiver
  import afr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic [4:0] position_o,
  output logic       frame_end_o,
  output logic [1:0] frame_kind_o,
  output logic [1:0] status_o
);

  // Classified request bytes travel through the queue as one struct.
  afr_item_t push_item, pop_item;
  logic      q_push, q_pop, q_full, q_empty;

  // Front end: classify start, info and length nibble; stall only when the queue is full.
  afr_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  // Decouple the two sides; a push and a pop may happen in the same cycle.
  afr_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (pop_item)
  );

  // Back end: hold frame position, kind and checksum; drop to a new frame at each end.
  afr_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_item_i     (pop_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_out_o   (byte_out_o),
    .position_o   (position_o),
    .frame_end_o  (frame_end_o),
    .frame_kind_o (frame_kind_o),
    .status_o     (status_o)
  );

endmodule

// ===== verif/frame_echo_checker.sv =====
// Checker for the adapter frame receiver: predicts each echoed byte and compares results.
module frame_echo_checker
  import afr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] byte_out_i,
  input  logic [4:0] position_i,
  input  logic       frame_end_i,
  input  logic [1:0] frame_kind_i,
  input  logic [1:0] status_i,
  output int         failures_o,
  output int         pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  byte_val;
    logic [4:0]  pos;
    logic        fend;
    afr_kind_e   kind;
    afr_status_e status;
  } echo_t;

  echo_t expected_echo_q[$];

  // Frame tracking state, mirrors the block after reset.
  logic [4:0] next_pos   = '0;
  logic [7:0] info_seen  = '0;
  logic       start_seen = 1'b0;
  logic [7:0] csum       = '0;
  logic [4:0] frame_len  = ShortLen;

  int fail_count    = 0;
  int pending_count = 0;

  assign failures_o = fail_count;
  assign pending_o  = pending_count;

  function automatic afr_kind_e kind_of(input logic started, input logic [7:0] info);
    if (!started) return KIND_SHORT;
    if (info == SettingsInfo) return KIND_SETTINGS;
    if (info[7:4] == DataNibble) return KIND_DATA;
    return KIND_SHORT;
  endfunction

  task predict_echo(input logic [7:0] b);
    echo_t e;
    e.byte_val = b;
    e.pos      = next_pos;
    e.fend     = 1'b0;
    e.kind     = KIND_SHORT;
    e.status   = ST_GOOD;
    if (next_pos == 0) begin
      start_seen = (b == StartByte);
      csum       = '0;
      frame_len  = ShortLen;
    end else begin
      if (next_pos == 1) begin
        info_seen = b;
        e.kind    = kind_of(start_seen, b);
        case (e.kind)
          KIND_SETTINGS: frame_len = SettingsLen;
          KIND_DATA:     frame_len = DataBaseLen + {1'b0, b[3:0]};
          default:       frame_len = ShortLen;
        endcase
      end else begin
        e.kind = kind_of(start_seen, info_seen);
      end
      if (int'(next_pos) + 1 >= int'(frame_len)) begin
        e.fend = 1'b1;
        // Settings frames end in a checksum, so skip the stop-byte test there.
        if (e.kind == KIND_SETTINGS) begin
          if (b != csum) e.status = ST_CHECKSUM;
        end else if (b != StopByte) begin
          e.status = ST_NO_STOP;
        end
      end else if (next_pos >= 2) begin
        csum = csum + b;
      end
    end
    if (e.fend) begin
      next_pos  = '0;
      frame_len = ShortLen;
      csum      = '0;
    end else begin
      next_pos = next_pos + 5'd1;
    end
    expected_echo_q.insert(expected_echo_q.size(), e);
  endtask

  task automatic flag(input string what, input int exp_v, input int act_v);
    $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    echo_t e;
    if (rst_ni) begin
      // Retire the result first: it always belongs to an earlier request.
      if (out_valid_i && !out_stall_i) begin
        if (expected_echo_q.size() == 0) begin
          $display("%0t ns: result with no request pending: expected none, actual byte %0d",
                   $time, byte_out_i);
          fail_count++;
        end else begin
          e = expected_echo_q.pop_front();
          if (byte_out_i !== e.byte_val) flag("byte_out", e.byte_val, byte_out_i);
          if (position_i !== e.pos) flag("position", e.pos, position_i);
          if (frame_end_i !== e.fend) flag("frame_end", e.fend, frame_end_i);
          if (frame_kind_i !== e.kind) flag("frame_kind", e.kind, frame_kind_i);
          if (status_i !== e.status) flag("status", e.status, status_i);
        end
      end
      if (in_valid_i && !in_stall_i) predict_echo(rx_byte_i);
      pending_count = expected_echo_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the adapter frame receiver testbench: clock, reset, byte stimulus and verdict.
module testbench
  import afr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = '0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] byte_out_o;
  logic [4:0] position_o;
  logic       frame_end_o;
  logic [1:0] frame_kind_o;
  logic [1:0] status_o;

  int failures;
  int pending;
  int cycle_count   = 0;
  int bytes_sent    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  bit hold_req      = 1'b0;
  bit hold_seen     = 1'b0;

  adapter_frame_receiver dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_out_o   (byte_out_o),
    .position_o   (position_o),
    .frame_end_o  (frame_end_o),
    .frame_kind_o (frame_kind_o),
    .status_o     (status_o)
  );

  frame_echo_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_out_i   (byte_out_o),
    .position_i   (position_o),
    .frame_end_i  (frame_end_o),
    .frame_kind_i (frame_kind_o),
    .status_i     (status_o),
    .failures_o   (failures),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver side: random stall per cycle, or a long hold-off when one is requested.
  // The hold-off lets the block fill up so that it has to stall its own input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req && !hold_seen) begin
        hold_seen   = 1'b1;
        hold_left   = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offer one request byte and hold it until the block takes it.
  // Called at a falling edge; returns at a falling edge with valid still high,
  // so back-to-back requests never toggle valid within one step.
  task send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Any byte but the start byte, so that the frame stays two bytes long.
  function automatic logic [7:0] not_start(input logic [7:0] b);
    return (b == StartByte) ? 8'h00 : b;
  endfunction

  task send_data_frame(input logic [3:0] nib, input bit good_stop);
    int i;
    send_byte(StartByte);
    send_byte({DataNibble, nib});
    for (i = 0; i < int'(nib) + 2; i++) send_byte(8'($urandom));
    send_byte(good_stop ? StopByte : 8'($urandom));
  endtask

  task send_settings_frame(input bit good_sum);
    int i;
    logic [7:0] b;
    logic [7:0] sum;
    sum = '0;
    send_byte(StartByte);
    send_byte(SettingsInfo);
    for (i = 0; i < 17; i++) begin
      b = 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    send_byte(good_sum ? sum : sum + 8'(1 + $urandom_range(0, 254)));
  endtask

  // Mostly well-formed frames with random content; the rest short frames and noise
  // that can knock the block off frame alignment.
  task send_random_frame();
    int pick;
    int i;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_data_frame(4'($urandom_range(0, 15)), $urandom_range(0, 9) != 0);
    end else if (pick < 65) begin
      send_settings_frame($urandom_range(0, 4) != 0);
    end else if (pick < 82) begin
      if ($urandom_range(0, 1) != 0) begin
        send_byte(not_start(8'($urandom)));
        send_byte(($urandom_range(0, 1) != 0) ? StopByte : 8'($urandom));
      end else begin
        // Start byte with an info byte that is neither settings nor data.
        b = 8'($urandom);
        if (b == SettingsInfo || b[7:4] == DataNibble) b = 8'h00;
        send_byte(StartByte);
        send_byte(b);
      end
    end else begin
      for (i = 0; i < $urandom_range(1, 3); i++) send_byte(8'($urandom));
    end
  endtask

  task run_phase(input int s_pct, input int r_pct, input int goal, input bit with_hold);
    bit hold_done;
    hold_done     = 1'b0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    goal          = bytes_sent + goal;
    while (bytes_sent < goal) begin
      if (with_hold && !hold_done && bytes_sent + 400 < goal) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      send_random_frame();
    end
  endtask

  initial begin
    send_idle_pct = 13;
    recv_idle_pct = 51;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Two-byte frames: good stop, then extreme bytes with a missing stop.
    send_byte(8'h00);
    send_byte(StopByte);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // Start byte followed by an info byte that picks neither kind.
    send_byte(StartByte);
    send_byte(8'h12);
    // Shortest data frame with its stop byte.
    send_data_frame(4'h0, 1'b1);
    // Settings frame with a bad checksum, reaching the last position.
    send_settings_frame(1'b0);

    run_phase(13, 51, 510, 1'b0);
    run_phase(51, 13, 510, 1'b0);
    run_phase(0, 0, 510, 1'b1);

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
